>>> design/rdr_pkg.sv
package rdr_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_SPEED    = 2'd0;
    localparam logic [1:0] CFG_RAMP_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_HEADING_GAIN = 2'd2;

    localparam logic [7:0]  MAX_SPEED_RST    = 8'd200;
    localparam logic [23:0] RAMP_LENGTH_RST  = 24'd1600;
    localparam logic [15:0] HEADING_GAIN_RST = 16'd256;

    // whole turns added so the degree count is never negative before mod 360
    localparam logic signed [25:0] MOD_OFF = 26'sd8388720;
    // floor(2^32 / 360)
    localparam logic [23:0] RECIP360  = 24'd11930464;
    // ceil(2^16 / 5)
    localparam logic [13:0] RECIP5    = 14'd13108;
    // ceil(2^26 / 1000)
    localparam logic [16:0] RECIP1000 = 17'd67109;
    localparam logic [6:0]  ROT_CAP   = 7'd70;

    typedef enum logic [1:0] {
        RGN_CRUISE,
        RGN_UP,
        RGN_DOWN
    } t_region;

    typedef struct packed {
        logic [7:0]         left_speed;
        logic [7:0]         right_speed;
        logic               left_reverse;
        logic               right_reverse;
        logic               step_done;
        logic signed [24:0] step_progress;
    } t_out;

endpackage

>>> design/rdr_if.sv
interface rdr_item_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [23:0] target;
    logic [23:0]        left_distance;
    logic [23:0]        right_distance;
    logic signed [13:0] heading_error;

    modport source(output valid, mode, target, left_distance, right_distance, heading_error,
                   input ready);
    modport sink(input valid, mode, target, left_distance, right_distance, heading_error,
                 output ready);
endinterface

interface rdr_result_if;
    logic               valid;
    logic               ready;
    logic [7:0]         left_speed;
    logic [7:0]         right_speed;
    logic               left_reverse;
    logic               right_reverse;
    logic               step_done;
    logic signed [24:0] step_progress;

    modport source(output valid, left_speed, right_speed, left_reverse, right_reverse,
                   step_done, step_progress, input ready);
    modport sink(input valid, left_speed, right_speed, left_reverse, right_reverse,
                 step_done, step_progress, output ready);
endinterface

interface rdr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> design/rover_drive_rotate_speed.sv
// Rover wheel speed controller, one item per control tick. Drive items get a
// trapezoidal speed profile on the larger wheel distance with gyro heading
// correction; rotate items get a cubic turn speed on the normalized angle error,
// capped at 70. The block takes one item per clock and returns one result per
// item, in order, through 10 front stages (profile setup, angle mod 360,
// the cubic), 16 stages of a restoring divider that resolves one quotient bit
// each, and 4 finish stages (heading offset, scaling, clamp). A two-entry result
// buffer sits at the output; the pipeline stalls only when that buffer is full,
// so input ready is a register-driven signal. Configuration writes are taken at
// any time (ready is always high) and must be done while no item is in flight.
module rover_drive_rotate_speed #(
    parameter int FRAC_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdr_item_if.sink    i_item,
    rdr_result_if.source o_item,
    rdr_cfg_if.sink     i_cfg
);
    import rdr_pkg::*;

    localparam int ONE     = 1 << FRAC_BITS;
    localparam int FULL    = 360 * ONE;
    localparam int HALF    = 180 * ONE;
    localparam int QTR     = ONE / 4;
    localparam int LO_MASK = ONE - 1;
    localparam int AW      = $clog2(FULL) + 1;           // normalized angle, signed
    localparam int EW      = ((AW > 14) ? AW : 14) + 1;  // angle error, signed
    localparam int SAT     = 31 * ONE;                    // speed is capped from here on
    localparam int MW      = $clog2(SAT);
    localparam int M2W     = 2 * MW;
    localparam int M3W     = 3 * MW;
    localparam int T1W     = MW + 13;
    localparam int T2W     = 2 * MW + 9;
    localparam int PW      = 3 * MW + 10;
    localparam int SH3     = 3 * FRAC_BITS;
    localparam int VW      = FRAC_BITS + 38;
    localparam int NF      = 10;
    localparam int ND      = 16;
    localparam int NB      = 3;
    localparam int NST     = NF + ND + NB + 1;

    // front stages: both modes are worked in parallel, mode picks at the end
    typedef struct packed {
        logic               mode;
        logic signed [23:0] target;
        logic signed [13:0] heading;
        logic [23:0]        cur;
        logic               done_d;
        logic signed [25:0] ramp2;
        logic signed [25:0] diff;
        t_region            region;
        logic [24:0]        dvs;
        logic [26:0]        kval;
        logic [40:0]        num;
        logic signed [29:0] hg;
        logic [24:0]        u;
        logic [16:0]        qe;
        logic [8:0]         r;
        logic signed [AW-1:0] a;
        logic signed [EW-1:0] err;
        logic               sat;
        logic               done_r;
        logic               lrev;
        logic [MW-1:0]      mc;
        logic [M2W-1:0]     m2;
        logic [T1W-1:0]     t1;
        logic [M3W-1:0]     m3;
        logic [T2W-1:0]     t2;
        logic [PW-1:0]      p;
        logic               big;
        logic [33:0]        xm;
    } t_front;

    typedef struct packed {
        logic               mode;
        t_region            region;
        logic [24:0]        rem;
        logic [15:0]        nlo;
        logic [15:0]        q;
        logic [24:0]        dvs;
        logic signed [29:0] hg;
        logic [23:0]        cur;
        logic               done_d;
        logic [6:0]         rspd;
        logic               lrev;
        logic               done_r;
        logic signed [13:0] heading;
    } t_div;

    typedef struct packed {
        logic               mode;
        t_region            region;
        logic [23:0]        cur;
        logic               done_d;
        logic [6:0]         rspd;
        logic               lrev;
        logic               done_r;
        logic signed [13:0] heading;
        logic [15:0]        prof;
        logic signed [33:0] off;
        logic signed [VW-1:0] yl;
        logic signed [VW-1:0] yr;
        logic               lneg;
        logic               lovf;
        logic [10:0]        lyc;
        logic [24:0]        lprod;
        logic               rneg;
        logic               rovf;
        logic [10:0]        ryc;
        logic [24:0]        rprod;
    } t_back;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    function automatic t_div div_step(t_div s);
        t_div        o;
        logic [25:0] t;
        o = s;
        t = {s.rem, s.nlo[15]};
        if (t >= {1'b0, s.dvs}) begin
            o.rem = 25'(t - {1'b0, s.dvs});
            o.q   = {s.q[14:0], 1'b1};
        end else begin
            o.rem = t[24:0];
            o.q   = {s.q[14:0], 1'b0};
        end
        o.nlo = {s.nlo[14:0], 1'b0};
        return o;
    endfunction

    logic [7:0]  r_max_speed;
    logic [23:0] r_ramp_len;
    logic [15:0] r_gain;

    logic [NST-1:0] r_v;
    t_front r_f [NF];
    t_front n_f [NF];
    t_div   r_d [ND];
    t_div   n_d [ND];
    t_back  r_b [NB];
    t_back  n_b [NB];
    t_out   r_out;
    t_out   n_out;
    t_div   c_load;

    t_out        r_fifo [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        en;
    logic        push;
    logic        pop;

    // whole pipeline moves together; only a full result buffer holds it
    assign en   = (r_cnt != 2'd2);
    assign push = en && r_v[NST-1];
    assign pop  = (r_cnt != 2'd0) && o_item.ready;

    assign i_item.ready = en;
    assign i_cfg.ready  = 1'b1;

    assign o_item.valid         = (r_cnt != 2'd0);
    assign o_item.left_speed    = r_fifo[r_rp].left_speed;
    assign o_item.right_speed   = r_fifo[r_rp].right_speed;
    assign o_item.left_reverse  = r_fifo[r_rp].left_reverse;
    assign o_item.right_reverse = r_fifo[r_rp].right_reverse;
    assign o_item.step_done     = r_fifo[r_rp].step_done;
    assign o_item.step_progress = r_fifo[r_rp].step_progress;

    // ---------------- front stages ----------------
    always_comb begin
        logic [23:0]          c_cur;
        logic signed [25:0]   c_tgt;
        logic signed [25:0]   c_cur_s;
        logic signed [25:0]   c_r2l;
        logic signed [25:0]   c_thi;
        logic signed [25:0]   c_ad;
        logic [24:0]          c_cur2;
        logic [26:0]          c_err2;
        logic                 c_pos;
        logic                 c_up;
        logic                 c_down;
        logic signed [30:0]   c_hg;
        logic [48:0]          c_qprod;
        logic [24:0]          c_r0;
        logic [AW-1:0]        c_apos;
        logic signed [EW-1:0] c_mag;
        logic [16:0]          c_x;

        // stage 0: larger wheel, effective ramp (in half units), turn count offset
        n_f[0]         = '0;
        n_f[0].mode    = i_item.mode;
        n_f[0].target  = i_item.target;
        n_f[0].heading = i_item.heading_error;
        c_cur = (i_item.left_distance > i_item.right_distance) ?
                i_item.left_distance : i_item.right_distance;
        n_f[0].cur     = c_cur;
        c_tgt   = {{2{i_item.target[23]}}, i_item.target};
        c_cur_s = {2'b00, c_cur};
        c_r2l   = {1'b0, r_ramp_len, 1'b0};
        n_f[0].done_d = (c_cur_s >= c_tgt);
        n_f[0].ramp2  = (c_tgt < c_r2l) ? c_tgt : c_r2l;
        n_f[0].diff   = c_tgt - c_cur_s;
        c_thi = (c_tgt >>> FRAC_BITS) + MOD_OFF;
        n_f[0].u = c_thi[24:0];

        // stage 1: pick ramp region, divider operands, gyro product, u / 360 estimate
        n_f[1] = r_f[0];
        c_cur2 = {r_f[0].cur, 1'b0};
        c_pos  = (r_f[0].ramp2 > 26'sd0);
        c_up   = c_pos && ($signed({1'b0, c_cur2}) < r_f[0].ramp2);
        c_ad   = r_f[0].diff[25] ? -r_f[0].diff : r_f[0].diff;
        c_err2 = {c_ad, 1'b0};
        c_down = c_pos && !c_up && (c_err2 < {2'b00, r_f[0].ramp2[24:0]});
        if (c_up) begin
            n_f[1].region = RGN_UP;
            n_f[1].kval   = {1'b0, r_f[0].cur, 2'b00};
        end else if (c_down) begin
            n_f[1].region = RGN_DOWN;
            n_f[1].kval   = 27'(c_err2 + {c_err2[25:0], 1'b0});
        end else begin
            n_f[1].region = RGN_CRUISE;
            n_f[1].kval   = '0;
        end
        n_f[1].dvs = c_pos ? r_f[0].ramp2[24:0] : 25'd1;
        c_hg = $signed(r_f[0].heading) * $signed({1'b0, r_gain});
        n_f[1].hg = c_hg[29:0];
        c_qprod = 49'(r_f[0].u) * 49'(RECIP360);
        n_f[1].qe = c_qprod[48:32];

        // stage 2: dividend, degree count mod 360 (estimate is low by at most one)
        n_f[2] = r_f[1];
        n_f[2].num = (41'(r_f[1].kval) * 41'(r_max_speed)) << 6;
        c_r0 = r_f[1].u - 25'(26'(r_f[1].qe) * 26'd360);
        n_f[2].r = (c_r0 >= 25'd360) ? 9'(c_r0 - 25'd360) : c_r0[8:0];

        // stage 3: angle into (-180, 180] degrees
        n_f[3] = r_f[2];
        c_apos = (AW'(r_f[2].r) << FRAC_BITS) |
                 AW'(unsigned'(r_f[2].target) & 24'(LO_MASK));
        n_f[3].a = (c_apos > AW'(HALF)) ? $signed(c_apos - AW'(FULL)) : $signed(c_apos);

        // stage 4: angle error
        n_f[4] = r_f[3];
        n_f[4].err = EW'($signed(r_f[3].a)) - EW'($signed(r_f[3].heading));

        // stage 5: magnitude, direction, done, cap check (cubic rises monotonically)
        n_f[5] = r_f[4];
        c_mag = (r_f[4].err < 0) ? -r_f[4].err : r_f[4].err;
        n_f[5].lrev   = !(r_f[4].err > 0);
        n_f[5].done_r = (c_mag <= EW'(QTR));
        n_f[5].sat    = (c_mag >= EW'(SAT));
        n_f[5].mc     = (c_mag >= EW'(SAT)) ? '0 : MW'(c_mag);

        // stages 6..8: cubic terms
        n_f[6] = r_f[5];
        n_f[6].m2 = M2W'(r_f[5].mc) * M2W'(r_f[5].mc);
        n_f[6].t1 = T1W'(r_f[5].mc) * T1W'(5917);

        n_f[7] = r_f[6];
        n_f[7].m3 = M3W'(r_f[6].m2) * M3W'(r_f[6].mc);
        n_f[7].t2 = T2W'(r_f[6].m2) * T2W'(300);

        n_f[8] = r_f[7];
        n_f[8].p = (PW'(r_f[7].t1) << (2 * FRAC_BITS)) + PW'(r_f[7].m3) * PW'(6) -
                   (PW'(r_f[7].t2) << FRAC_BITS);

        // stage 9: scale out fraction bits, divide by 1000 via reciprocal
        n_f[9] = r_f[8];
        c_x = 17'(r_f[8].p >> SH3);
        n_f[9].big = (c_x >= 17'd70000);
        n_f[9].xm  = 34'(c_x) * 34'(RECIP1000);
    end

    // ---------------- divider ----------------
    always_comb begin
        c_load         = '0;
        c_load.mode    = r_f[NF-1].mode;
        c_load.region  = r_f[NF-1].region;
        c_load.rem     = r_f[NF-1].num[40:16];
        c_load.nlo     = r_f[NF-1].num[15:0];
        c_load.q       = '0;
        c_load.dvs     = r_f[NF-1].dvs;
        c_load.hg      = r_f[NF-1].hg;
        c_load.cur     = r_f[NF-1].cur;
        c_load.done_d  = r_f[NF-1].done_d;
        c_load.rspd    = (r_f[NF-1].sat || r_f[NF-1].big) ? ROT_CAP :
                         7'(r_f[NF-1].xm >> 26);
        c_load.lrev    = r_f[NF-1].lrev;
        c_load.done_r  = r_f[NF-1].done_r;
        c_load.heading = r_f[NF-1].heading;
        n_d[0] = div_step(c_load);
        for (int k = 1; k < ND; k++) begin
            n_d[k] = div_step(r_d[k-1]);
        end
    end

    // ---------------- finish stages ----------------
    always_comb begin
        logic [15:0]          c_base;
        logic signed [33:0]   c_hg34;
        logic signed [VW-1:0] c_ps;
        logic signed [VW-1:0] c_lv;
        logic signed [VW-1:0] c_rv;
        logic signed [VW-1:0] c_lim;

        // profile speed in 1/256 units, heading offset times ramp gain factor
        n_b[0]         = '0;
        n_b[0].mode    = r_d[ND-1].mode;
        n_b[0].region  = r_d[ND-1].region;
        n_b[0].cur     = r_d[ND-1].cur;
        n_b[0].done_d  = r_d[ND-1].done_d;
        n_b[0].rspd    = r_d[ND-1].rspd;
        n_b[0].lrev    = r_d[ND-1].lrev;
        n_b[0].done_r  = r_d[ND-1].done_r;
        n_b[0].heading = r_d[ND-1].heading;
        c_hg34 = 34'(r_d[ND-1].hg);
        case (r_d[ND-1].region)
            RGN_UP: begin
                c_base = {1'b0, r_max_speed, 7'b0};
                n_b[0].off = (c_hg34 <<< 2) + (c_hg34 <<< 1);
            end
            RGN_DOWN: begin
                c_base = {2'b00, r_max_speed, 6'b0};
                n_b[0].off = (c_hg34 <<< 1) + c_hg34;
            end
            default: begin
                c_base = {r_max_speed, 8'b0};
                n_b[0].off = c_hg34;
            end
        endcase
        n_b[0].prof = c_base + r_d[ND-1].q;

        // both wheels, shifted down by 256 * one (* 2 in the down ramp)
        n_b[1] = r_b[0];
        c_ps = $signed(VW'(r_b[0].prof) << FRAC_BITS);
        case (r_b[0].region)
            RGN_UP:   c_ps = (c_ps <<< 2) + c_ps;
            RGN_DOWN: c_ps = c_ps <<< 1;
            default:  c_ps = c_ps;
        endcase
        c_lv = c_ps - VW'(r_b[0].off);
        c_rv = c_ps + VW'(r_b[0].off);
        if (r_b[0].region == RGN_DOWN) begin
            n_b[1].yl = c_lv >>> (9 + FRAC_BITS);
            n_b[1].yr = c_rv >>> (9 + FRAC_BITS);
        end else begin
            n_b[1].yl = c_lv >>> (8 + FRAC_BITS);
            n_b[1].yr = c_rv >>> (8 + FRAC_BITS);
        end

        // clamp flags; up ramp still needs a divide by 5
        n_b[2] = r_b[1];
        c_lim = (r_b[1].region == RGN_UP) ? VW'(1280) : VW'(256);
        n_b[2].lneg  = (r_b[1].yl < 0);
        n_b[2].lovf  = (r_b[1].yl >= c_lim);
        n_b[2].lyc   = r_b[1].yl[10:0];
        n_b[2].lprod = 25'(r_b[1].yl[10:0]) * 25'(RECIP5);
        n_b[2].rneg  = (r_b[1].yr < 0);
        n_b[2].rovf  = (r_b[1].yr >= c_lim);
        n_b[2].ryc   = r_b[1].yr[10:0];
        n_b[2].rprod = 25'(r_b[1].yr[10:0]) * 25'(RECIP5);
    end

    always_comb begin
        logic [7:0] c_ls;
        logic [7:0] c_rs;
        if (r_b[2].lneg)                  c_ls = 8'd0;
        else if (r_b[2].lovf)             c_ls = 8'd255;
        else if (r_b[2].region == RGN_UP) c_ls = r_b[2].lprod[23:16];
        else                              c_ls = r_b[2].lyc[7:0];
        if (r_b[2].rneg)                  c_rs = 8'd0;
        else if (r_b[2].rovf)             c_rs = 8'd255;
        else if (r_b[2].region == RGN_UP) c_rs = r_b[2].rprod[23:16];
        else                              c_rs = r_b[2].ryc[7:0];
        if (r_b[2].mode) begin
            n_out.left_speed    = {1'b0, r_b[2].rspd};
            n_out.right_speed   = {1'b0, r_b[2].rspd};
            n_out.left_reverse  = r_b[2].lrev;
            n_out.right_reverse = !r_b[2].lrev;
            n_out.step_done     = r_b[2].done_r;
            n_out.step_progress = 25'($signed(r_b[2].heading));
        end else begin
            n_out.left_speed    = c_ls;
            n_out.right_speed   = c_rs;
            n_out.left_reverse  = 1'b0;
            n_out.right_reverse = 1'b0;
            n_out.step_done     = r_b[2].done_d;
            n_out.step_progress = $signed({1'b0, r_b[2].cur});
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= MAX_SPEED_RST;
            r_ramp_len  <= RAMP_LENGTH_RST;
            r_gain      <= HEADING_GAIN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAX_SPEED:    r_max_speed <= i_cfg.data[7:0];
                CFG_RAMP_LENGTH:  r_ramp_len  <= i_cfg.data;
                CFG_HEADING_GAIN: r_gain      <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (en) begin
                r_v <= {r_v[NST-2:0], i_item.valid};
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f   <= n_f;
            r_d   <= n_d;
            r_b   <= n_b;
            r_out <= n_out;
        end
        if (push) begin
            r_fifo[r_wp] <= r_out;
        end
    end

endmodule
